// ----- hw/rtl/scid_pkg.sv -----
// ----------------------------------------------------------------------------
// scid_pkg : shared types and constants of the identifier parser
// Holds the parse state and result records, the character codes and the
// field masks used by the step logic and the top level.
// ----------------------------------------------------------------------------
package scid_pkg;

  localparam int unsigned WIDE_W   = 24;
  localparam int unsigned NARROW_W = 16;

  localparam logic [WIDE_W-1:0] MASK_WIDE   = 24'hFF_FFFF;
  localparam logic [WIDE_W-1:0] MASK_NARROW = 24'h00_FFFF;

  localparam logic [7:0] CHAR_SEP  = 8'h78;  // 'x'
  localparam logic [7:0] CHAR_ZERO = 8'h30;  // '0'
  localparam logic [7:0] CHAR_NINE = 8'h39;  // '9'

  // part being read
  localparam logic [1:0] PART_BLOCK = 2'd0;
  localparam logic [1:0] PART_TX    = 2'd1;
  localparam logic [1:0] PART_OUT   = 2'd2;

  typedef struct packed {
    logic [1:0]        part_number;
    logic [WIDE_W-1:0] accumulator;
    logic [WIDE_W-1:0] saved_block;
    logic [WIDE_W-1:0] saved_tx;
    logic              digit_seen;
    logic              error_flag;
  } parse_state_t;

  typedef struct packed {
    logic                parse_ok;
    logic [WIDE_W-1:0]   block_height;
    logic [WIDE_W-1:0]   tx_index;
    logic [NARROW_W-1:0] output_index;
  } parse_result_t;

  localparam parse_state_t STATE_RESET = '{
    part_number: PART_BLOCK,
    accumulator: '0,
    saved_block: '0,
    saved_tx:    '0,
    digit_seen:  1'b0,
    error_flag:  1'b0
  };

endpackage

// ----- hw/rtl/scid_step_logic.sv -----
// ----------------------------------------------------------------------------
// scid_step_logic : one-byte update of the parse state
// Applies a single character to the current state and forms the result
// that would be given if this character closes the string.
// ----------------------------------------------------------------------------
module scid_step_logic (
  input  scid_pkg::parse_state_t  cur,
  input  logic [7:0]              char_byte,
  output scid_pkg::parse_state_t  nxt,
  output scid_pkg::parse_result_t result
);

  logic [27:0]                  times_ten;
  logic [27:0]                  wide_sum;
  logic [scid_pkg::WIDE_W-1:0]  masked;
  logic [7:0]                   digit;
  logic                         ok;

  assign digit     = char_byte - scid_pkg::CHAR_ZERO;
  // acc*10 as (acc<<3) + (acc<<1)
  assign times_ten = {1'b0, cur.accumulator, 3'b000} + {3'b000, cur.accumulator, 1'b0};
  assign wide_sum  = times_ten + {24'd0, digit[3:0]};
  assign masked    = (cur.part_number >= scid_pkg::PART_OUT) ?
                     (wide_sum[scid_pkg::WIDE_W-1:0] & scid_pkg::MASK_NARROW) :
                     (wide_sum[scid_pkg::WIDE_W-1:0] & scid_pkg::MASK_WIDE);

  always_comb begin
    nxt = cur;
    if (!cur.error_flag) begin
      if (char_byte == scid_pkg::CHAR_SEP) begin
        if ((cur.part_number >= scid_pkg::PART_OUT) || !cur.digit_seen) begin
          nxt.error_flag = 1'b1;
        end else begin
          if (cur.part_number == scid_pkg::PART_BLOCK) begin
            nxt.saved_block = cur.accumulator;
          end else begin
            nxt.saved_tx = cur.accumulator;
          end
          nxt.part_number = cur.part_number + 2'd1;
          nxt.accumulator = '0;
          nxt.digit_seen  = 1'b0;
        end
      end else if ((char_byte < scid_pkg::CHAR_ZERO) || (char_byte > scid_pkg::CHAR_NINE)) begin
        nxt.error_flag = 1'b1;
      end else if (masked < cur.accumulator) begin
        // wrapped under the mask
        nxt.error_flag = 1'b1;
      end else begin
        nxt.accumulator = masked;
        nxt.digit_seen  = 1'b1;
      end
    end
  end

  assign ok = !nxt.error_flag && (nxt.part_number == scid_pkg::PART_OUT) && nxt.digit_seen;

  always_comb begin
    result.parse_ok     = ok;
    result.block_height = ok ? nxt.saved_block : '0;
    result.tx_index     = ok ? nxt.saved_tx : '0;
    result.output_index = ok ? nxt.accumulator[scid_pkg::NARROW_W-1:0] : '0;
  end

endmodule

// ----- hw/rtl/scid_string_parser_unit.sv -----
// ----------------------------------------------------------------------------
// scid_string_parser_unit : streaming parser for BLOCKxTXxOUT identifiers
// Takes one character word per cycle (less while m_axis stalls) and gives one result word per string.
// ----------------------------------------------------------------------------
// Path: the input register takes the last character word; the result
//   register loads from the step logic once that word advances, which
//   waits while m_axis stalls, and the result word then shows on m_axis.
// Throughput: one character word per cycle while m_axis does not stall a
//   last one; the multiply-by-ten, add and compare are combinational.
// Reset: rst (synchronous, active high) empties both registers and returns
//   the parse state to the first part with nothing seen.
// ----------------------------------------------------------------------------
module scid_string_parser_unit (
  input  logic        clk,
  input  logic        rst,
  // character stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
  input  logic        s_axis_tlast,   // last_char
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [23:0] block_height, [47:24] tx_index,
                                      // [63:48] output_index
  output logic        m_axis_tuser    // parse_ok
);

  // input register
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_last;

  // parse state and its update
  scid_pkg::parse_state_t  state;
  scid_pkg::parse_state_t  state_next;
  scid_pkg::parse_result_t step_result;

  // result register
  logic                    out_valid;
  scid_pkg::parse_result_t out_word;

  logic advance;

  // A character that closes no string never touches the result register,
  // so only a last character has to wait for room there.
  assign advance       = in_valid && (!in_last || !out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Hold the character until the parse stage takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  scid_step_logic u_step (
    .cur       (state),
    .char_byte (in_char),
    .nxt       (state_next),
    .result    (step_result)
  );

  // Advance the parse state; drop back to the start after the last character.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scid_pkg::STATE_RESET;
    end else if (advance) begin
      if (in_last) begin
        state <= scid_pkg::STATE_RESET;
      end else begin
        state <= state_next;
      end
    end
  end

  // Load the result word on a last character, clear it once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_last) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_word <= step_result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_word.parse_ok;
  assign m_axis_tdata  = {out_word.output_index, out_word.tx_index, out_word.block_height};

endmodule

// ----- hw/rtl/scid_checker.sv -----
// ----------------------------------------------------------------------------
// scid_checker : port-level checks of the identifier parser
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module scid_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // a stalled result word stays offered
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  // a stalled result word keeps its contents
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result word changed while stalled");

  // a failed parse reports all fields as zero
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 64'd0))
    else $error("failed parse carries non-zero fields");

  // with the result side empty the input side never stalls
  assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with no result pending");

  // no result word straight after reset
  assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result word offered after reset");

endmodule

bind scid_string_parser_unit scid_checker u_scid_checker (.*);

// ----- bench/scid_string_parser_unit_tb.sv -----
// ----------------------------------------------------------------------------
// scid_string_parser_unit_tb : self-checking bench for the identifier parser
// Feeds character strings through the input stream, directed cases first and
// then random well-formed, broken and noise strings. A scoreboard mirrors
// the parse state, predicts the result word for each string and checks every
// result word in order. Both streams stall at random.
// ----------------------------------------------------------------------------
module scid_string_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Mirrors the parse state and holds the result words still to come.
  class scid_scoreboard;
    scid_pkg::parse_state_t  st;
    scid_pkg::parse_result_t expected_q[$];
    int unsigned             mismatches;

    function void clear_state();
      st = scid_pkg::STATE_RESET;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Advance the mirror by one accepted character word.
    function void note_char(logic [7:0] ch, logic last);
      logic [35:0]                 wide;
      logic [scid_pkg::WIDE_W-1:0] mask;
      logic [scid_pkg::WIDE_W-1:0] next;
      logic                        ok;
      scid_pkg::parse_result_t     res;
      if (!st.error_flag) begin
        if (ch == scid_pkg::CHAR_SEP) begin
          if (st.part_number >= scid_pkg::PART_OUT || !st.digit_seen) begin
            st.error_flag = 1'b1;
          end else begin
            if (st.part_number == scid_pkg::PART_BLOCK) st.saved_block = st.accumulator;
            else st.saved_tx = st.accumulator;
            st.part_number = st.part_number + 2'd1;
            st.accumulator = '0;
            st.digit_seen  = 1'b0;
          end
        end else if (ch < scid_pkg::CHAR_ZERO || ch > scid_pkg::CHAR_NINE) begin
          st.error_flag = 1'b1;
        end else begin
          mask = (st.part_number >= scid_pkg::PART_OUT) ? scid_pkg::MASK_NARROW :
                                                          scid_pkg::MASK_WIDE;
          wide = 36'(st.accumulator) * 36'd10 + 36'(ch - scid_pkg::CHAR_ZERO);
          next = wide[scid_pkg::WIDE_W-1:0] & mask;
          if (next < st.accumulator) begin
            st.error_flag = 1'b1;
          end else begin
            st.accumulator = next;
            st.digit_seen  = 1'b1;
          end
        end
      end
      if (last) begin
        ok               = !st.error_flag && st.part_number == scid_pkg::PART_OUT &&
                           st.digit_seen;
        res.parse_ok     = ok;
        res.block_height = ok ? st.saved_block : '0;
        res.tx_index     = ok ? st.saved_tx : '0;
        res.output_index = ok ? st.accumulator[scid_pkg::NARROW_W-1:0] : '0;
        expected_q.push_back(res);
        clear_state();
      end
    endfunction

    // Compare one accepted result word with the oldest prediction.
    function void check_result(logic ok, logic [63:0] data);
      scid_pkg::parse_result_t got;
      scid_pkg::parse_result_t want;
      got.parse_ok     = ok;
      got.block_height = data[23:0];
      got.tx_index     = data[47:24];
      got.output_index = data[63:48];
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result ok=%0b block=%0d tx=%0d out=%0d", $realtime,
                   got.parse_ok, got.block_height, got.tx_index, got.output_index);
        return;
      end
      want = expected_q.pop_front();
      if (got.parse_ok !== want.parse_ok || got.block_height !== want.block_height ||
          got.tx_index !== want.tx_index || got.output_index !== want.output_index) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result mismatch exp ok=%0b block=%0d tx=%0d out=%0d, got ok=%0b block=%0d tx=%0d out=%0d",
                   $realtime, want.parse_ok, want.block_height, want.tx_index,
                   want.output_index, got.parse_ok, got.block_height, got.tx_index,
                   got.output_index);
      end
    endfunction

    // Count predictions that never got a result word.
    function void drain_check();
      if (expected_q.size() != 0) begin
        if (mismatches < 10)
          $display("%0d result words never arrived", expected_q.size());
        mismatches += expected_q.size();
      end
    endfunction

    function bit failed();
      return mismatches != 0;
    endfunction
  endclass

  logic        clk;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] char_byte
  logic        s_axis_tlast  = 1'b0;    // last_char
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;            // [23:0] block_height, [47:24] tx_index,
                                        // [63:48] output_index
  logic        m_axis_tuser;            // parse_ok

  scid_scoreboard sb;
  logic [7:0]     text_q[$];   // string being built, sent with tlast on its final byte
  bit             quiet      = 1'b0;   // no idling on either side while set
  int unsigned    words_sent = 0;

  scid_string_parser_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side: stall about one cycle in five, except in the quiet stretch.
  always @(negedge clk) begin
    m_axis_tready <= !rst && (quiet || $urandom_range(99) >= 21);
  end

  // Sample both handshakes at the rising edge and feed the scoreboard.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_char(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
    end
  end

  // Present one character word, idling first at random, and hold it until taken.
  task automatic drive_word(input logic [7:0] ch, input logic last);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 21) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    words_sent++;
  endtask

  // Send the built string as one frame and empty the buffer.
  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) drive_word(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic append_literal(input string txt);
    for (int i = 0; i < txt.len(); i++) text_q.push_back(txt[i]);
  endtask

  // One decimal part: mostly short, sometimes the widest value or one past it.
  task automatic append_part(input int part);
    int unsigned r;
    int unsigned n;
    r = $urandom_range(99);
    if (r < 5) begin
      if (part == 2) append_literal("65535");
      else append_literal("16777215");
    end else if (r < 8) begin
      if (part == 2) append_literal("65536");
      else append_literal("16777216");
    end else begin
      n = (r < 90) ? $urandom_range(1, 5) : $urandom_range(6, 9);
      repeat (n) text_q.push_back(8'(scid_pkg::CHAR_ZERO + $urandom_range(0, 9)));
    end
  endtask

  task automatic build_wellformed();
    append_part(0);
    text_q.push_back(scid_pkg::CHAR_SEP);
    append_part(1);
    text_q.push_back(scid_pkg::CHAR_SEP);
    append_part(2);
  endtask

  initial begin
    int unsigned kind;
    int unsigned idx;
    int unsigned len;
    bit          paused;
    sb = new();
    sb.clear_state();
    paused = 1'b0;

    // Hold reset, then release it away from the rising edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed strings: smallest identifier, too few separators, empty first
    // part, empty third part, a third separator, a bad byte followed by a
    // well-formed tail, and overflow of the narrow part.
    append_literal("0x0x0");     send_text();
    append_literal("1x2");       send_text();
    append_literal("x");         send_text();
    append_literal("1x2x");      send_text();
    append_literal("1x2x3x");    send_text();
    append_literal("/1x2x3");    send_text();
    append_literal("0x0x65536"); send_text();

    while (words_sent < 1650) begin
      quiet = (words_sent >= 900 && words_sent < 1200);
      // Drain the result stream completely once, after the first 500 character words.
      if (!paused && words_sent >= 500) begin
        paused = 1'b1;
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
      kind = $urandom_range(99);
      if (kind < 65) begin
        build_wellformed();
      end else if (kind < 80) begin
        // Break a well-formed string: corrupt, add a separator, drop or truncate.
        build_wellformed();
        idx = $urandom_range(0, text_q.size() - 1);
        case ($urandom_range(3))
          0: text_q[idx] = 8'($urandom_range(0, 255));
          1: text_q.insert(idx, scid_pkg::CHAR_SEP);
          2: text_q.delete(idx);
          default: while (text_q.size() > idx + 1) void'(text_q.pop_back());
        endcase
        if (text_q.size() == 0) text_q.push_back(scid_pkg::CHAR_SEP);
      end else begin
        // Noise: any byte, weighted towards digits and separators.
        len = $urandom_range(1, 8);
        repeat (len) begin
          case ($urandom_range(3))
            0: text_q.push_back(8'(scid_pkg::CHAR_ZERO + $urandom_range(0, 9)));
            1: text_q.push_back(scid_pkg::CHAR_SEP);
            default: text_q.push_back(8'($urandom_range(0, 255)));
          endcase
        end
      end
      send_text();
    end
    quiet = 1'b0;

    // Drop valid, wait for the last result words and let the pipeline settle.
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    sb.drain_check();
    if (!sb.failed()) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/scid_pkg.sv
hw/rtl/scid_step_logic.sv
hw/rtl/scid_string_parser_unit.sv
hw/rtl/scid_checker.sv
bench/scid_string_parser_unit_tb.sv
